@@ sv/dnsp_pkg.sv @@
`default_nettype none
package dnsp_pkg;

	// Field kind codes carried on field_kind.
	localparam logic [3:0] KIND_ID      = 4'd0;
	localparam logic [3:0] KIND_QNAME   = 4'd6;
	localparam logic [3:0] KIND_QTYPE   = 4'd7;
	localparam logic [3:0] KIND_QCLASS  = 4'd8;
	localparam logic [3:0] KIND_RNAME   = 4'd9;
	localparam logic [3:0] KIND_RTYPE   = 4'd10;
	localparam logic [3:0] KIND_RCLASS  = 4'd11;
	localparam logic [3:0] KIND_TTL     = 4'd12;
	localparam logic [3:0] KIND_RDLEN   = 4'd13;
	localparam logic [3:0] KIND_RDATA   = 4'd14;
	localparam logic [3:0] KIND_NAMEERR = 4'd15;

	// Header layout: twelve bytes, flags word at byte offsets 2 and 3.
	localparam logic [8:0]  HDR_LAST_OFF  = 9'd11;
	localparam logic [8:0]  HDR_FLAGS_OFF = 9'd3;
	localparam logic [15:0] FLAGS_MASK    = 16'hFF8F;

	// Parser phases, one-hot.
	typedef enum logic [11:0] {
		PH_IDLE   = 12'b0000_0000_0001,
		PH_HEADER = 12'b0000_0000_0010,
		PH_QNAME  = 12'b0000_0000_0100,
		PH_QTYPE  = 12'b0000_0000_1000,
		PH_QCLASS = 12'b0000_0001_0000,
		PH_RNAME  = 12'b0000_0010_0000,
		PH_RTYPE  = 12'b0000_0100_0000,
		PH_RCLASS = 12'b0000_1000_0000,
		PH_TTL    = 12'b0001_0000_0000,
		PH_RDLEN  = 12'b0010_0000_0000,
		PH_RDATA  = 12'b0100_0000_0000,
		PH_DONE   = 12'b1000_0000_0000
	} phase_t;

	// One result item.
	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] value;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

@@ sv/dnsp_parse.sv @@
`default_nettype none
module dnsp_parse import dnsp_pkg::*; #(
	parameter int NAME_MAX  = 256,
	parameter int RDATA_MAX = 512
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic       first_byte,
	output logic            res_valid,
	output result_t         res
);

	localparam logic [8:0]  NameLimit  = 9'(NAME_MAX);
	localparam logic [15:0] RdataLimit = 16'(RDATA_MAX);

	phase_t      phase_q, phase_n, phase_c;
	logic [1:0]  bif_q, bif_n, bif_c;
	logic [31:0] asm_q, asm_n, asm_c, asm_shift;
	logic [8:0]  nlen_q, nlen_n, nlen_c;
	logic [15:0] rrem_q, rrem_n, rrem_c, rrem_dec, rdlen_v;
	logic        ptr_q, ptr_n, ptr_c;
	logic        name_err;

	// A first byte restarts the parser from a cleared state in the header phase.
	always_comb begin
		if (first_byte) begin
			phase_c = PH_HEADER;
			bif_c   = '0;
			asm_c   = '0;
			nlen_c  = '0;
			rrem_c  = '0;
			ptr_c   = 1'b0;
		end else begin
			phase_c = phase_q;
			bif_c   = bif_q;
			asm_c   = asm_q;
			nlen_c  = nlen_q;
			rrem_c  = rrem_q;
			ptr_c   = ptr_q;
		end
	end

	assign asm_shift = {asm_c[23:0], data_byte};
	assign name_err  = (nlen_c >= NameLimit);
	assign rrem_dec  = rrem_c - 16'd1;
	assign rdlen_v   = asm_shift[15:0];

	// Next state and result for the current byte.
	always_comb begin
		phase_n   = phase_c;
		bif_n     = bif_c;
		asm_n     = asm_c;
		nlen_n    = nlen_c;
		rrem_n    = rrem_c;
		ptr_n     = ptr_c;
		res_valid = 1'b0;
		res.kind  = KIND_ID;
		res.value = asm_shift;
		res.last  = 1'b0;
		unique case (phase_c)
			PH_HEADER: begin
				asm_n  = {16'd0, asm_c[7:0], data_byte};
				nlen_n = nlen_c + 9'd1;
				if (nlen_c[0]) begin
					res_valid = 1'b1;
					res.kind  = nlen_c[4:1];
					res.value = {16'd0, asm_c[7:0], data_byte};
					if (nlen_c == HDR_FLAGS_OFF) begin
						res.value = {16'd0, {asm_c[7:0], data_byte} & FLAGS_MASK};
					end
					asm_n = '0;
					if (nlen_c >= HDR_LAST_OFF) begin
						phase_n = PH_QNAME;
						bif_n   = '0;
						nlen_n  = '0;
					end
				end
			end
			PH_QNAME, PH_RNAME: begin
				if (phase_c == PH_QNAME || !ptr_c) begin
					if (data_byte == 8'd0) begin
						phase_n = (phase_c == PH_QNAME) ? PH_QTYPE : PH_RTYPE;
						bif_n   = '0;
						asm_n   = '0;
					end
				end
				if (data_byte != 8'd0 || (phase_c == PH_RNAME && ptr_c)) begin
					res_valid = 1'b1;
					if (name_err) begin
						phase_n   = PH_DONE;
						res.kind  = KIND_NAMEERR;
						res.value = '0;
						res.last  = 1'b1;
					end else begin
						nlen_n    = nlen_c + 9'd1;
						res.kind  = (phase_c == PH_QNAME) ? KIND_QNAME : KIND_RNAME;
						res.value = {24'd0, data_byte};
					end
					// A compression pointer ends the record name after its second byte.
					if (phase_c == PH_RNAME) begin
						if (ptr_c) begin
							ptr_n = 1'b0;
							if (!name_err) begin
								phase_n = PH_RTYPE;
								bif_n   = '0;
								asm_n   = '0;
							end
						end else if (data_byte[7:6] == 2'b11) begin
							ptr_n = 1'b1;
						end
					end
				end
			end
			PH_QTYPE, PH_QCLASS, PH_RTYPE, PH_RCLASS, PH_TTL, PH_RDLEN: begin
				asm_n = asm_shift;
				if (bif_c == ((phase_c == PH_TTL) ? 2'd3 : 2'd1)) begin
					res_valid = 1'b1;
					bif_n     = '0;
					asm_n     = '0;
					unique case (phase_c)
						PH_QTYPE: begin
							res.kind = KIND_QTYPE;
							phase_n  = PH_QCLASS;
						end
						PH_QCLASS: begin
							res.kind = KIND_QCLASS;
							phase_n  = PH_RNAME;
							nlen_n   = '0;
							ptr_n    = 1'b0;
						end
						PH_RTYPE: begin
							res.kind = KIND_RTYPE;
							phase_n  = PH_RCLASS;
						end
						PH_RCLASS: begin
							res.kind = KIND_RCLASS;
							phase_n  = PH_TTL;
						end
						PH_TTL: begin
							res.kind = KIND_TTL;
							phase_n  = PH_RDLEN;
						end
						default: begin
							res.kind  = KIND_RDLEN;
							res.value = {16'd0, rdlen_v};
							rrem_n    = (rdlen_v > RdataLimit) ? RdataLimit : rdlen_v;
							res.last  = (rdlen_v == 16'd0);
							phase_n   = (rdlen_v == 16'd0) ? PH_DONE : PH_RDATA;
						end
					endcase
				end else begin
					bif_n = bif_c + 2'd1;
				end
			end
			PH_RDATA: begin
				rrem_n    = rrem_dec;
				res_valid = 1'b1;
				res.kind  = KIND_RDATA;
				res.value = {24'd0, data_byte};
				res.last  = (rrem_dec == 16'd0);
				if (rrem_dec == 16'd0) begin
					phase_n = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	// Parser state registers, updated once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bif_q   <= '0;
			asm_q   <= '0;
			nlen_q  <= '0;
			rrem_q  <= '0;
			ptr_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			bif_q   <= bif_n;
			asm_q   <= asm_n;
			nlen_q  <= nlen_n;
			rrem_q  <= rrem_n;
			ptr_q   <= ptr_n;
		end
	end

endmodule
`default_nettype wire

@@ sv/dnsp_outbuf.sv @@
`default_nettype none
module dnsp_outbuf import dnsp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire result_t  push_res,
	output logic          full,
	output logic          out_valid,
	input  wire logic     out_ready,
	output result_t       out_res
);

	logic    main_valid_q, skid_valid_q, pop;
	result_t main_q, skid_q;

	assign pop       = main_valid_q && out_ready;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_res   = main_q;

	// Output register with one skid entry; the input side sees only the registered full flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_valid_q && !pop) begin
				skid_q <= push_res;
			end else begin
				main_q <= push_res;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/dns_response_field_parser.sv @@
// A byte is registered at the input and its result item at the output buffer.
// Throughput: one byte per cycle unless the skid entry is full; one parser step per byte.
// The skid stage's registered full flag, not out_ready, gates input acceptance.
// Reset (arst_n low, asynchronous) idles the parser; bytes are ignored until first_byte.
`default_nettype none
module dns_response_field_parser import dnsp_pkg::*; #(
	parameter int NAME_MAX  = 256,
	parameter int RDATA_MAX = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        first_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       field_kind,
	output logic [31:0]      field_value,
	output logic             last_item
);

	logic       valid_s1, advance, buf_full, res_valid;
	logic [7:0] data_s1;
	logic       first_s1;
	result_t    res, out_res;

	assign advance  = valid_s1 && !buf_full;
	assign in_ready = !valid_s1 || !buf_full;

	// Input register for the item being parsed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
		end
	end

	dnsp_parse #(
		.NAME_MAX  (NAME_MAX),
		.RDATA_MAX (RDATA_MAX)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (data_s1),
		.first_byte (first_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	dnsp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && res_valid),
		.push_res  (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign field_kind  = out_res.kind;
	assign field_value = out_res.value;
	assign last_item   = out_res.last;

endmodule
`default_nettype wire

@@ dv/tb_dns_response_field_parser.sv @@
`timescale 1ns / 1ps
module tb_dns_response_field_parser;
	import dnsp_pkg::*;

	localparam int NAME_LIMIT = 256;
	localparam int RDATA_LIMIT = 512;
	localparam logic [7:0] PTR_TAG = 8'hC0;
	localparam int RX_STALL_CYCLES = 300;
	localparam int TAIL_CYCLES = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_REPORTS = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'd0;
	logic first_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] field_kind;
	logic [31:0] field_value;
	logic last_item;

	// Fields the parser still owes us, oldest first.
	result_t expected_fields[$];
	logic [7:0] msg_bytes[$];

	int error_count = 0;
	int active_items = 0;
	int send_idle_pct = 24;
	int recv_idle_pct = 67;
	int stall_requests = 0;
	int stall_served = 0;
	int stall_left = 0;
	int cycle_count;

	// Parser state mirrored by the testbench.
	phase_t mdl_phase = PH_IDLE;
	logic [1:0] mdl_field_byte = '0;
	logic [31:0] mdl_shift = '0;
	logic [8:0] mdl_name_len = '0;
	logic [15:0] mdl_rdata_left = '0;
	logic mdl_ptr_pending = 1'b0;

	dns_response_field_parser #(
		.NAME_MAX (NAME_LIMIT),
		.RDATA_MAX(RDATA_LIMIT)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.field_kind (field_kind),
		.field_value(field_value),
		.last_item  (last_item)
	);

	// Free-running clock, 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: a hung block ends the run here.
	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
		$display("FAIL");
		$finish;
	end

	function automatic result_t make_result(input logic [3:0] kind, input logic [31:0] value,
			input logic last);
		result_t r;
		r.kind = kind;
		r.value = value;
		r.last = last;
		return r;
	endfunction

	function automatic void start_field(input phase_t ph);
		mdl_phase = ph;
		mdl_field_byte = '0;
		mdl_shift = '0;
	endfunction

	// Shifts in one byte of a fixed-size field; true once the field is complete.
	function automatic bit take_field(input logic [7:0] b, input int nbytes);
		mdl_shift = (mdl_shift << 8) | {24'd0, b};
		if (int'(mdl_field_byte) + 1 >= nbytes) return 1'b1;
		mdl_field_byte = mdl_field_byte + 2'd1;
		return 1'b0;
	endfunction

	// A name byte, or the error item once the name has grown past its limit.
	function automatic result_t take_name_byte(input logic [7:0] b, input logic [3:0] kind);
		if (int'(mdl_name_len) >= NAME_LIMIT) begin
			mdl_phase = PH_DONE;
			return make_result(KIND_NAMEERR, 32'd0, 1'b1);
		end
		mdl_name_len = mdl_name_len + 9'd1;
		return make_result(kind, {24'd0, b}, 1'b0);
	endfunction

	// Advances the mirrored parser by one byte; returns 1 when a field item is due.
	function automatic bit parse_byte(input logic [7:0] b, input logic first,
			output result_t r);
		logic [8:0] off;
		logic [31:0] v;
		bit produced;
		produced = 1'b0;
		r = make_result(KIND_ID, 32'd0, 1'b0);
		if (first) begin
			start_field(PH_HEADER);
			mdl_name_len = '0;
			mdl_rdata_left = '0;
			mdl_ptr_pending = 1'b0;
		end
		case (mdl_phase)
			PH_HEADER: begin
				// The byte offset lives in the name counter while in the header.
				off = mdl_name_len;
				mdl_shift = ((mdl_shift << 8) | {24'd0, b}) & 32'h0000_FFFF;
				mdl_name_len = off + 9'd1;
				if (off[0]) begin
					v = mdl_shift;
					if (off == HDR_FLAGS_OFF) v = v & {16'd0, FLAGS_MASK};
					r = make_result(KIND_ID + 4'(off >> 1), v, 1'b0);
					produced = 1'b1;
					mdl_shift = '0;
					if (off >= HDR_LAST_OFF) begin
						start_field(PH_QNAME);
						mdl_name_len = '0;
					end
				end
			end
			PH_QNAME: begin
				if (b == 8'd0) begin
					start_field(PH_QTYPE);
				end else begin
					r = take_name_byte(b, KIND_QNAME);
					produced = 1'b1;
				end
			end
			PH_QTYPE: begin
				if (take_field(b, 2)) begin
					r = make_result(KIND_QTYPE, mdl_shift, 1'b0);
					produced = 1'b1;
					start_field(PH_QCLASS);
				end
			end
			PH_QCLASS: begin
				if (take_field(b, 2)) begin
					r = make_result(KIND_QCLASS, mdl_shift, 1'b0);
					produced = 1'b1;
					start_field(PH_RNAME);
					mdl_name_len = '0;
					mdl_ptr_pending = 1'b0;
				end
			end
			PH_RNAME: begin
				// The second pointer byte ends the name, whatever its value.
				if (mdl_ptr_pending) begin
					r = take_name_byte(b, KIND_RNAME);
					produced = 1'b1;
					mdl_ptr_pending = 1'b0;
					if (mdl_phase == PH_RNAME) start_field(PH_RTYPE);
				end else if (b == 8'd0) begin
					start_field(PH_RTYPE);
				end else begin
					if ((b & PTR_TAG) == PTR_TAG) mdl_ptr_pending = 1'b1;
					r = take_name_byte(b, KIND_RNAME);
					produced = 1'b1;
				end
			end
			PH_RTYPE: begin
				if (take_field(b, 2)) begin
					r = make_result(KIND_RTYPE, mdl_shift, 1'b0);
					produced = 1'b1;
					start_field(PH_RCLASS);
				end
			end
			PH_RCLASS: begin
				if (take_field(b, 2)) begin
					r = make_result(KIND_RCLASS, mdl_shift, 1'b0);
					produced = 1'b1;
					start_field(PH_TTL);
				end
			end
			PH_TTL: begin
				if (take_field(b, 4)) begin
					r = make_result(KIND_TTL, mdl_shift, 1'b0);
					produced = 1'b1;
					start_field(PH_RDLEN);
				end
			end
			PH_RDLEN: begin
				// Rdata longer than the limit is cut short.
				if (take_field(b, 2)) begin
					v = {16'd0, mdl_shift[15:0]};
					if (v > RDATA_LIMIT) mdl_rdata_left = 16'(RDATA_LIMIT);
					else mdl_rdata_left = v[15:0];
					r = make_result(KIND_RDLEN, v, mdl_rdata_left == 16'd0);
					produced = 1'b1;
					if (mdl_rdata_left == 16'd0) start_field(PH_DONE);
					else start_field(PH_RDATA);
				end
			end
			PH_RDATA: begin
				mdl_rdata_left = mdl_rdata_left - 16'd1;
				r = make_result(KIND_RDATA, {24'd0, b}, mdl_rdata_left == 16'd0);
				produced = 1'b1;
				if (mdl_rdata_left == 16'd0) mdl_phase = PH_DONE;
			end
			default: begin
			end
		endcase
		return produced;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (error_count < MAX_REPORTS) begin
			$display("mismatch at %0t: %s got %0h, wanted %0h", $realtime, what, got, want);
		end
		error_count++;
	endtask

	// Sends one item, with random idle cycles first, and predicts its result.
	task automatic send_byte(input logic [7:0] b, input logic first);
		result_t r;
		bit accepted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		first_byte <= first;
		do begin
			@(negedge clk);
			accepted = in_ready;
			@(posedge clk);
		end while (!accepted);
		if (first || (mdl_phase != PH_IDLE && mdl_phase != PH_DONE)) active_items++;
		if (parse_byte(b, first, r)) expected_fields.push_back(r);
	endtask

	// Holds the sender back until every predicted field has come out.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_fields.size() != 0) @(posedge clk);
	endtask

	task automatic put_word(input logic [31:0] v, input int nbytes);
		int i;
		for (i = nbytes - 1; i >= 0; i--) msg_bytes.push_back(v[8 * i +: 8]);
	endtask

	// Builds a message with random content and the given shape.
	task automatic build_message(input int qlen, input int rlen, input bit rptr,
			input int rdlen, input int rdata_count);
		int i;
		msg_bytes.delete();
		for (i = 0; i < 12; i++) put_word($urandom, 1);
		// The question name may hold pointer-like bytes; it does not treat them specially.
		for (i = 0; i < qlen; i++) put_word($urandom_range(1, 255), 1);
		put_word(32'd0, 1);
		put_word($urandom, 4);
		for (i = 0; i < rlen; i++) put_word($urandom_range(1, 191), 1);
		if (rptr) begin
			put_word({24'd0, PTR_TAG} | $urandom_range(0, 63), 1);
			put_word($urandom, 1);
		end else begin
			put_word(32'd0, 1);
		end
		put_word($urandom, 4);
		put_word($urandom, 4);
		put_word(rdlen, 2);
		for (i = 0; i < rdata_count; i++) put_word($urandom, 1);
	endtask

	task automatic send_message(input int keep);
		int i;
		for (i = 0; i < keep; i++) send_byte(msg_bytes[i], i == 0);
	endtask

	// One random message: mostly well formed, some truncated, oversized or plain noise.
	task automatic send_random_message();
		int pick, i, qlen, rlen, rdlen;
		bit rptr;
		pick = $urandom_range(0, 99);
		qlen = $urandom_range(0, 10);
		rlen = $urandom_range(0, 8);
		rptr = $urandom_range(0, 2) != 0;
		rdlen = $urandom_range(0, 12);
		if (pick < 10) begin
			for (i = $urandom_range(1, 12); i > 0; i--) begin
				send_byte(8'($urandom), $urandom_range(0, 7) == 0);
			end
		end else begin
			if (pick < 13) begin
				case ($urandom_range(0, 2))
					0: qlen = $urandom_range(250, 260);
					1: rlen = $urandom_range(250, 260);
					default: rdlen = $urandom_range(500, 65535);
				endcase
			end
			build_message(qlen, rlen, rptr, rdlen,
				(rdlen > RDATA_LIMIT) ? RDATA_LIMIT + 2 : rdlen);
			if (pick < 22) begin
				send_message($urandom_range(1, msg_bytes.size() - 1));
			end else begin
				for (i = $urandom_range(0, 2); i > 0; i--) put_word($urandom, 1);
				send_message(msg_bytes.size());
			end
		end
	endtask

	// Receiver: random ready, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_served != stall_requests) begin
			stall_served <= stall_requests;
			stall_left <= RX_STALL_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Compares every delivered item with the oldest predicted field.
	always @(negedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_fields.size() == 0) begin
				report_mismatch("item with none expected, kind", {28'd0, field_kind}, 32'd0);
			end else begin
				want = expected_fields.pop_front();
				if (field_kind !== want.kind) begin
					report_mismatch("field_kind", {28'd0, field_kind}, {28'd0, want.kind});
				end
				if (field_value !== want.value) begin
					report_mismatch("field_value", field_value, want.value);
				end
				if (last_item !== want.last) begin
					report_mismatch("last_item", {31'd0, last_item}, {31'd0, want.last});
				end
			end
		end
	end

	// Bytes before any first_byte must be dropped.
	task automatic test_idle_bytes();
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	// A message cut off in its header; the next test's first byte restarts the parser.
	task automatic test_restart_midway();
		send_byte(8'h12, 1'b1);
		send_byte(8'h34, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
	endtask

	// Extreme header values, empty question name, pointer-only answer name,
	// empty rdata ending the message, and a byte after the end.
	task automatic test_extreme_message();
		msg_bytes.delete();
		put_word(32'hFFFF_FFFF, 4);
		put_word(32'h0000_0000, 4);
		put_word(32'hFFFF_FFFF, 4);
		put_word(32'd0, 1);
		put_word(32'hFFFF_0000, 4);
		put_word(32'h0000_FF00, 2);
		put_word(32'h0000_FFFF, 4);
		put_word(32'hFFFF_FFFF, 4);
		put_word(32'd0, 2);
		put_word(32'h0000_00FF, 1);
		send_message(msg_bytes.size());
		wait_for_results();
	endtask

	// Names that reach the limit and go one byte past it, and rdata past its cap.
	task automatic test_long_fields();
		build_message(NAME_LIMIT + 1, 0, 1'b0, 0, 0);
		send_message(msg_bytes.size());
		build_message(0, NAME_LIMIT - 1, 1'b1, 1, 1);
		send_message(msg_bytes.size());
		build_message(1, 1, 1'b1, RDATA_LIMIT + 1, RDATA_LIMIT + 3);
		send_message(msg_bytes.size());
		wait_for_results();
	endtask

	// Receiver holds off while the sender keeps pushing, so the input stalls.
	task automatic test_output_stall();
		int saved_pct;
		saved_pct = send_idle_pct;
		send_idle_pct = 0;
		stall_requests <= stall_requests + 1;
		build_message(20, 6, 1'b1, 24, 24);
		send_message(msg_bytes.size());
		wait_for_results();
		send_idle_pct = saved_pct;
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
			input int target);
		int start_count;
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
		start_count = active_items;
		while (active_items - start_count < target) send_random_message();
		wait_for_results();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_bytes();
		test_restart_midway();
		test_extreme_message();
		test_random_traffic(24, 67, 210);
		test_output_stall();
		test_random_traffic(67, 24, 210);
		test_long_fields();
		test_random_traffic(0, 0, 210);

		// Leave room for stray results.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_fields.size() != 0) begin
			report_mismatch("fields never delivered", expected_fields.size(), 32'd0);
		end
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ dns_response_field_parser.f @@
sv/dnsp_pkg.sv
sv/dnsp_parse.sv
sv/dnsp_outbuf.sv
sv/dns_response_field_parser.sv
dv/tb_dns_response_field_parser.sv
